@@ design/ldpd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ldpd_pkg
// shared types, sizes and microcode program of the least-loaded dispatcher
// ----------------------------------------------------------------------------
package ldpd_pkg;

   localparam int MAX_SERVERS  = 16;
   localparam int LOAD_WIDTH   = 16;
   localparam int REG_W        = 5;
   localparam int ID_W         = 4;
   localparam int IDX_W        = $clog2(MAX_SERVERS);
   localparam int CNT_W        = REG_W;
   localparam int REQ_TDATA_W  = 8;
   localparam int RSP_TDATA_W  = 8;
   localparam logic [REG_W-1:0] ACTIVE_RESET = REG_W'(16);

   typedef enum logic [1:0] {
      STEP_WAIT   = 2'd0,
      STEP_INIT   = 2'd1,
      STEP_SCAN   = 2'd2,
      STEP_COMMIT = 2'd3
   } step_type;

   typedef enum logic [2:0] {
      COND_NEVER    = 3'd0,
      COND_NO_REQ   = 3'd1,
      COND_LAST     = 3'd2,
      COND_NOT_LAST = 3'd3,
      COND_OUT_BUSY = 3'd4
   } cond_type;

   typedef struct packed {
      logic     accept;
      logic     rd_zero;
      logic     init_best;
      logic     compare;
      logic     commit;
      cond_type cond;
      step_type target;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic last;
      logic out_busy;
   } status_type;

   // microcode program: taken jump goes to target, otherwise next step
   function automatic ctrl_type ucode(input step_type step);
      ctrl_type w;
      w = '{accept: 1'b0, rd_zero: 1'b0, init_best: 1'b0, compare: 1'b0,
            commit: 1'b0, cond: COND_NEVER, target: STEP_WAIT};
      unique case (step)
         STEP_WAIT: begin
            w.accept  = 1'b1;
            w.rd_zero = 1'b1;
            w.cond    = COND_NO_REQ;
            w.target  = STEP_WAIT;
         end
         STEP_INIT: begin
            w.init_best = 1'b1;
            w.cond      = COND_LAST;
            w.target    = STEP_COMMIT;
         end
         STEP_SCAN: begin
            w.compare = 1'b1;
            w.cond    = COND_NOT_LAST;
            w.target  = STEP_SCAN;
         end
         STEP_COMMIT: begin
            w.commit = 1'b1;
            w.cond   = COND_OUT_BUSY;
            w.target = STEP_COMMIT;
         end
         default: begin
            w.cond = COND_NEVER;
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

@@ design/ldpd_sequencer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ldpd_sequencer
// step counter with conditional jumps over the microcode program
// ----------------------------------------------------------------------------
module ldpd_sequencer (
   input  wire                   clock,
   input  wire                   reset,
   input  ldpd_pkg::status_type  status,
   output ldpd_pkg::ctrl_type    ctrl,
   output ldpd_pkg::step_type    step
);
   import ldpd_pkg::*;

   step_type step_ff;
   step_type step_in;
   logic     taken;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      ctrl = ucode(step_ff);
      unique case (ctrl.cond)
         COND_NEVER:    taken = 1'b0;
         COND_NO_REQ:   taken = !status.req_valid;
         COND_LAST:     taken = status.last;
         COND_NOT_LAST: taken = !status.last;
         COND_OUT_BUSY: taken = status.out_busy;
         default:       taken = 1'b0;
      endcase
      if (taken) begin
         step_in = ctrl.target;
      end else begin
         step_in = step_type'(step_ff + 2'd1);
      end
   end

   assign step = step_ff;

endmodule
`default_nettype wire

@@ design/ldpd_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ldpd_datapath
// load memory, scan counter, comparator and result register
// ----------------------------------------------------------------------------
module ldpd_datapath (
   input  wire                               clock,
   input  wire                               reset,
   input  ldpd_pkg::ctrl_type                ctrl,
   input  wire                               req_fire,
   input  wire  [ldpd_pkg::REG_W-1:0]        req_count,
   input  wire                               rsp_ready,
   input  wire                               csr_wr_en,
   input  wire  [ldpd_pkg::REG_W-1:0]        csr_wr_data,
   output ldpd_pkg::status_type              status,
   output logic                              rsp_valid,
   output logic [ldpd_pkg::ID_W-1:0]         rsp_id
);
   import ldpd_pkg::*;

   logic [LOAD_WIDTH-1:0]  load_mem [MAX_SERVERS];
   logic [MAX_SERVERS-1:0] load_valid_ff;
   logic [LOAD_WIDTH-1:0]  rd_load_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic [REG_W-1:0]       active_ff;
   logic [CNT_W-1:0]       limit_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [CNT_W-1:0]       cnt_in;
   logic [CNT_W-1:0]       cnt_next;
   logic [IDX_W-1:0]       best_ff;
   logic [LOAD_WIDTH-1:0]  best_load_ff;
   logic [REG_W-1:0]       eff_active;
   logic [CNT_W-1:0]       clamped;
   logic                   rsp_valid_ff;
   logic [ID_W-1:0]        rsp_id_ff;
   logic                   out_busy;
   logic                   do_write;
   logic [LOAD_WIDTH-1:0]  new_load;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_wr_en) begin
         active_ff <= csr_wr_data;
      end
   end

   // effective range of eligible servers
   always_comb begin
      eff_active = active_ff;
      if (active_ff == '0) begin
         eff_active = REG_W'(1);
      end else if (MAX_SERVERS < (1 << REG_W) && active_ff > REG_W'(MAX_SERVERS)) begin
         eff_active = REG_W'(MAX_SERVERS);
      end
      if (req_count > eff_active) begin
         clamped = CNT_W'(eff_active);
      end else begin
         clamped = CNT_W'(req_count);
      end
   end

   assign cnt_next = cnt_ff + CNT_W'(1);
   assign rd_addr  = ctrl.rd_zero ? '0 : IDX_W'(cnt_next);
   assign out_busy = rsp_valid_ff && !rsp_ready;
   assign do_write = ctrl.commit && !out_busy;
   assign new_load = (best_load_ff == '1) ? best_load_ff : best_load_ff + LOAD_WIDTH'(1);

   always_comb begin
      cnt_in = cnt_ff;
      if (req_fire) begin
         cnt_in = '0;
      end else if (ctrl.init_best || ctrl.compare) begin
         cnt_in = cnt_next;
      end
   end

   // scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         limit_ff <= clamped;
      end
      if (ctrl.init_best) begin
         best_ff      <= '0;
         best_load_ff <= rd_load_ff;
      end else if (ctrl.compare && rd_load_ff < best_load_ff) begin
         best_ff      <= IDX_W'(cnt_ff);
         best_load_ff <= rd_load_ff;
      end
   end

   // load memory, unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (do_write) begin
         load_mem[best_ff] <= new_load;
      end
      rd_load_ff <= load_valid_ff[rd_addr] ? load_mem[rd_addr] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_valid_ff <= '0;
      end else if (do_write) begin
         load_valid_ff[best_ff] <= 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_write) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         rsp_id_ff <= ID_W'(best_ff);
      end
   end

   assign status.req_valid = 1'b0;
   assign status.last      = (cnt_next >= limit_ff);
   assign status.out_busy  = out_busy;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_id           = rsp_id_ff;

endmodule
`default_nettype wire

@@ design/least_loaded_prefix_dispatcher_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// least_loaded_prefix_dispatcher_core
// assigns each request to the least-loaded server in an eligible prefix
// ----------------------------------------------------------------------------
// Each request word carries an eligible count; the block picks the server with
// the smallest load among servers 0 to count-1 (clamped to the active server
// count, zero treated as one), lower index on ties, returns its index and bumps
// its saturating load counter. A request runs init, any scan steps and commit:
// one comparator walks the load memory one counter per cycle through its
// single registered read port, under a four-step microprogram. The next
// request is taken while a result still waits in the output register.
module least_loaded_prefix_dispatcher_core (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [ldpd_pkg::REQ_TDATA_W-1:0]      req_tdata,   // [4:0] eligible_count
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [ldpd_pkg::RSP_TDATA_W-1:0]      rsp_tdata,   // [3:0] srv_index
   input  wire                                   csr_wr_en,
   input  wire  [ldpd_pkg::REG_W-1:0]            csr_wr_data  // active_servers
);
   import ldpd_pkg::*;

   ctrl_type   ctrl;
   step_type   step;
   status_type dp_status;
   status_type seq_status;
   logic       req_fire;
   logic [ID_W-1:0] rsp_id;

   assign req_tready = ctrl.accept && !reset;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      seq_status           = dp_status;
      seq_status.req_valid = req_tvalid;
   end

   ldpd_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (seq_status),
      .ctrl   (ctrl),
      .step   (step)
   );

   ldpd_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .req_fire    (req_fire),
      .req_count   (req_tdata[REG_W-1:0]),
      .rsp_ready   (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (dp_status),
      .rsp_valid   (rsp_tvalid),
      .rsp_id      (rsp_id)
   );

   assign rsp_tdata = {{(RSP_TDATA_W-ID_W){1'b0}}, rsp_id};

   // accepted request always starts the scan
   a_fire_init: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> step == STEP_INIT)
      else $error("scan did not start after request");

   // a new result comes only out of the commit step
   a_rsp_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(step == STEP_COMMIT))
      else $error("result raised outside commit step");

   // requests are taken only in the wait step
   a_ready_wait: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> step == STEP_WAIT)
      else $error("ready outside wait step");

endmodule
`default_nettype wire
